// ===== src/vt4_pkg.sv =====
package vt4_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int NUM_ROWS  = 4;
  localparam int NUM_COLS  = 4;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_W     = 2 * DATA_W;
  localparam int VEC_W     = NUM_COLS * DATA_W;

  localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(64'd1 << FRAC_BITS);
  localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << DATA_W;

  // identity matrix
  localparam logic [CFG_W-1:0] MAT_RESET [NUM_REGS] = '{
    ONE_LO, '0, ONE_HI, '0, '0, ONE_LO, '0, ONE_HI
  };

  localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef logic signed [DATA_W-1:0] elem_t;
  typedef elem_t                    row_t [NUM_COLS];

  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctrl_t;

endpackage

// ===== src/vt4_lane.sv =====
module vt4_lane
  import vt4_pkg::*;
(
  input  logic       clk,
  input  lane_ctrl_t ctrl,
  input  row_t       row,
  input  row_t       vec,
  output elem_t      dot,
  output logic       sat
);

  logic signed [PROD_W-1:0] prod [NUM_COLS];
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  shifted;
  logic [SUM_W-DATA_W:0]    upper;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        prod[c] <= PROD_W'(row[c]) * PROD_W'(vec[c]);
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      sum = sum + SUM_W'(prod[c]);
    end
    shifted = sum >>> FRAC_BITS;
    upper   = shifted[SUM_W-1:DATA_W-1];
    ovf     = !((&upper) || (~|upper));
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_sum) begin
      sat <= ovf;
      if (!ovf) begin
        dot <= shifted[DATA_W-1:0];
      end else if (shifted[SUM_W-1]) begin
        dot <= SAT_MIN;
      end else begin
        dot <= SAT_MAX;
      end
    end
  end

endmodule

// ===== src/vt4_merge.sv =====
module vt4_merge
  import vt4_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  row_t             dots,
  input  logic [NUM_ROWS-1:0] sats,
  output logic [VEC_W-1:0] tdata,
  output logic             tuser
);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < NUM_ROWS; r++) begin
        tdata[r*DATA_W +: DATA_W] <= dots[r];
      end
      tuser <= |sats;
    end
  end

endmodule

// ===== src/vertex_transform_4x4.sv =====
// 4x4 matrix times 4-component vector, signed Q16.16. Takes one vector per clock
// and returns one result per clock unless the output stalls, via a multiply
// stage (sixteen 32x32 multipliers, one lane per matrix row), a sum/shift/
// saturate stage, and an output register. Backpressure on the output stalls
// only stages that hold data, so bubbles are squeezed out. Each row sum is
// exact, shifted right by 16 toward minus infinity and clamped to 32 bits;
// m_tuser is set if any component was clamped. The matrix resets to identity.
// Load it via cfg_we/cfg_index/cfg_data only when idle; the block does not check.
module vertex_transform_4x4
  import vt4_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [VEC_W-1:0]     s_tdata,   // in_x, in_y, in_z, in_w
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [VEC_W-1:0]     m_tdata,   // out_x, out_y, out_z, out_w
  output logic                 m_tuser,   // saturated
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]    mat [NUM_REGS];
  logic                v_mul, v_sum;
  logic                en_mul, en_sum, en_out;
  lane_ctrl_t          ctrl;
  row_t                vec;
  row_t                rows [NUM_ROWS];
  row_t                dots;
  logic [NUM_ROWS-1:0] sats;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        mat[i] <= MAT_RESET[i];
      end
    end else if (cfg_we) begin
      mat[cfg_index] <= cfg_data;
    end
  end

  assign en_out   = !m_tvalid || m_tready;
  assign en_sum   = !v_sum || en_out;
  assign en_mul   = !v_mul || en_sum;
  assign s_tready = en_mul;
  assign ctrl     = '{en_mul: en_mul, en_sum: en_sum};

  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul    <= 1'b0;
      v_sum    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en_mul) v_mul <= s_tvalid;
      if (en_sum) v_sum <= v_mul;
      if (en_out) m_tvalid <= v_sum;
    end
  end

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_vec
    assign vec[c] = s_tdata[c*DATA_W +: DATA_W];
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
      assign rows[r][c] = mat[r*2 + c/2][(c%2)*DATA_W +: DATA_W];
    end

    vt4_lane u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .row  (rows[r]),
      .vec  (vec),
      .dot  (dots[r]),
      .sat  (sats[r])
    );
  end

  vt4_merge u_merge (
    .clk   (clk),
    .en    (en_out),
    .dots  (dots),
    .sats  (sats),
    .tdata (m_tdata),
    .tuser (m_tuser)
  );

endmodule

// ===== src/vt4_checker.sv =====
module vt4_checker
  import vt4_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [VEC_W-1:0]     m_tdata,
  input logic                 m_tuser
);

  logic [NUM_ROWS-1:0] at_limit;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      at_limit[r] = (m_tdata[r*DATA_W +: DATA_W] == SAT_MAX) ||
                    (m_tdata[r*DATA_W +: DATA_W] == SAT_MIN);
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_data_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output transaction changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (|at_limit))
    else $error("saturated flag set with no clamped component");

endmodule

bind vertex_transform_4x4 vt4_checker u_vt4_checker (.*);
